### rtl/rob_pkg.sv
// shared types and constants of the retry outbox
package rob_pkg;

    localparam int unsigned FUNC_W    = 3;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned OUTC_W    = 2;
    localparam int unsigned PAY_W     = 64;
    localparam int unsigned ATT_W     = 16;
    localparam int unsigned TIME_W    = 32;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CAP_W     = 7;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 32;

    localparam logic [FUNC_W-1:0] FN_ENQ  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DUE  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_MARK = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ACK  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_FIND = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONMONO  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

    localparam logic [OUTC_W-1:0] OUTC_BAD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX      = 2'd2;

    localparam logic [CAP_W-1:0]  DEF_CAPACITY = 7'd64;
    localparam logic [TIME_W-1:0] DEF_FIRST    = 32'd250;
    localparam logic [TIME_W-1:0] DEF_MAX      = 32'd5000;
    localparam logic [TIME_W-1:0] TIME_MAX     = 32'hFFFF_FFFF;
    localparam logic [ATT_W-1:0]  ATT_MAX      = 16'hFFFF;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [TAG_W-1:0]  action_tag;
        logic [OUTC_W-1:0] outcome_code;
        logic              position_finite;
        logic [PAY_W-1:0]  entry_payload;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                hit;
        logic [TAG_W-1:0]    hit_tag;
        logic [OUTC_W-1:0]   hit_outcome;
        logic [PAY_W-1:0]    hit_payload;
        logic [ATT_W-1:0]    hit_attempts;
        logic [CAP_W-1:0]    occupancy;
    } rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic scan_start; // reset scan index
        logic scan_step;  // read next slot
        logic bo_start;   // start backoff
        logic bo_step;    // one doubling step
        logic append;     // write new entry at tail
        logic update;     // write attempts and due time
        logic shift_step; // write last read entry one slot down
        logic shift_done; // drop tail
        logic set_time;   // record time
        logic finish;     // build result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_end;   // index reached fill count
        logic scan_rd;    // read data valid for index
        logic tag_match;
        logic due_match;
        logic bo_done;
        logic req_bad;
        logic time_bad;
        logic full;
        logic hit_late;   // found entry not yet due
    } sts_t;

endpackage

### rtl/rob_if.sv
// valid/ready channel carrying one payload
interface rob_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/retry_outbox_with_backoff_unit.sv
// top level of the retry outbox with backoff
// usage:
//  - requests enter on req_ch (valid/ready), one at a time; each gives
//    exactly one result on rsp_ch
//  - configuration is a plain write port (cfg_we, cfg_idx, cfg_data);
//    write only while no request is in flight
//  - a request walks the ordered table one slot at a time, each slot
//    read through a registered memory read, so a lookup takes longer
//    the more entries it scans
//  - mark attempt adds one doubling step at a time (at most attempts-1,
//    and no more than it takes the delay to reach the cap), then the update
//  - acknowledge moves each entry after the match down to close the gap,
//    read then write, then drops the tail
//  - the next request is taken once the result has been delivered
//  - reset clears the fill count, the time record and the controller;
//    entry memory needs no clearing since only filled slots are read
//  - when the receiver stalls the result register holds and no new
//    request is taken
module retry_outbox_with_backoff_unit #(
    parameter int unsigned DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    rob_if.sink                          req_ch,
    rob_if.source                        rsp_ch,
    input logic                          cfg_we,
    input logic [rob_pkg::CFG_IDX_W-1:0] cfg_idx,
    input logic [rob_pkg::CFG_DAT_W-1:0] cfg_data
);

    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    rob_pkg::cmd_t cmd;
    rob_pkg::sts_t sts;
    rob_pkg::req_t req;
    logic [rob_pkg::STATUS_W-1:0] res_status;
    logic res_hit;

    assign req = req_ch.data;

    // sequencer
    rob_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req_ch.valid),
        .in_ready   (req_ch.ready),
        .out_valid  (rsp_ch.valid),
        .out_ready  (rsp_ch.ready),
        .func       (req.func),
        .sts        (sts),
        .cmd        (cmd),
        .res_status (res_status),
        .res_hit    (res_hit)
    );

    // table, backoff and result register
    rob_datapath #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .res_status (res_status),
        .res_hit    (res_hit),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .sts        (sts),
        .rsp        (rsp_ch.data)
    );

endmodule

### rtl/rob_datapath.sv
// retry outbox datapath: entry memory, scan, backoff and result register
module rob_datapath #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned IDX_W = 6,
    parameter int unsigned CNT_W = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rob_pkg::req_t                 req,
    input  rob_pkg::cmd_t                 cmd,
    input  logic [rob_pkg::STATUS_W-1:0]  res_status,
    input  logic                          res_hit,
    input  logic                          cfg_we,
    input  logic [rob_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [rob_pkg::CFG_DAT_W-1:0] cfg_data,
    output rob_pkg::sts_t                 sts,
    output rob_pkg::rsp_t                 rsp
);

    localparam int unsigned ENT_W = rob_pkg::TAG_W + rob_pkg::OUTC_W + rob_pkg::PAY_W;
    localparam int unsigned SCH_W = rob_pkg::ATT_W + rob_pkg::TIME_W;
    localparam int unsigned CMP_W = (CNT_W > rob_pkg::CAP_W) ? CNT_W : rob_pkg::CAP_W;

    logic [ENT_W-1:0] ent_mem [DEPTH];
    logic [SCH_W-1:0] sch_mem [DEPTH];

    rob_pkg::req_t req_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [ENT_W-1:0] ent_rd_reg;
    logic [SCH_W-1:0] sch_rd_reg;
    logic rd_valid_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [rob_pkg::TIME_W-1:0] last_time_reg;
    logic time_seen_reg;
    logic [rob_pkg::CAP_W-1:0] cap_cfg_reg;
    logic [rob_pkg::TIME_W-1:0] first_cfg_reg;
    logic [rob_pkg::TIME_W-1:0] max_cfg_reg;
    logic [rob_pkg::TIME_W-1:0] delay_reg;
    logic [rob_pkg::ATT_W-1:0] bo_cnt_reg;
    logic [rob_pkg::ATT_W-1:0] att_new_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    rob_pkg::rsp_t rsp_reg;

    logic defaults;
    logic [rob_pkg::CAP_W-1:0] cap_eff;
    logic [rob_pkg::TIME_W-1:0] first_eff;
    logic [rob_pkg::TIME_W-1:0] max_eff;
    logic [rob_pkg::ATT_W-1:0] rd_att;
    logic [rob_pkg::TIME_W-1:0] rd_due;
    logic [rob_pkg::TAG_W-1:0] rd_tag;
    logic [rob_pkg::TIME_W:0] due_sum;
    logic [rob_pkg::TIME_W-1:0] due_new;
    logic [IDX_W-1:0] idx_lo;
    logic [IDX_W-1:0] rd_idx_dn;

    assign defaults  = (cap_cfg_reg == '0) || (first_cfg_reg == '0)
                       || (max_cfg_reg < first_cfg_reg);
    assign cap_eff   = defaults ? rob_pkg::DEF_CAPACITY : cap_cfg_reg;
    assign first_eff = defaults ? rob_pkg::DEF_FIRST : first_cfg_reg;
    assign max_eff   = defaults ? rob_pkg::DEF_MAX : max_cfg_reg;

    assign rd_tag    = ent_rd_reg[ENT_W-1 -: rob_pkg::TAG_W];
    assign rd_att    = sch_rd_reg[SCH_W-1 -: rob_pkg::ATT_W];
    assign rd_due    = sch_rd_reg[rob_pkg::TIME_W-1:0];
    assign idx_lo    = idx_reg[IDX_W-1:0];
    // slot just below the last read one, target of a shift
    assign rd_idx_dn = rd_idx_reg - IDX_W'(1);

    assign due_sum = {1'b0, req_reg.now_ms} + {1'b0, delay_reg};
    assign due_new = due_sum[rob_pkg::TIME_W] ? rob_pkg::TIME_MAX : due_sum[rob_pkg::TIME_W-1:0];

    always_comb
    begin
        sts.scan_end  = (idx_reg >= fill_reg);
        sts.scan_rd   = rd_valid_reg;
        sts.tag_match = rd_tag == req_reg.action_tag;
        sts.due_match = rd_due <= req_reg.now_ms;
        sts.hit_late  = rd_due > req_reg.now_ms;
        sts.bo_done   = (bo_cnt_reg <= rob_pkg::ATT_W'(1)) || (delay_reg >= max_eff);
        sts.req_bad   = (req_reg.func == rob_pkg::FN_ENQ)
                        ? (req_reg.action_tag == '0 || req_reg.outcome_code == rob_pkg::OUTC_BAD
                           || !req_reg.position_finite)
                        : (req_reg.action_tag == '0);
        sts.time_bad  = time_seen_reg && (req_reg.now_ms < last_time_reg);
        sts.full      = (CMP_W'(fill_reg) >= CMP_W'(cap_eff)) || (fill_reg >= CNT_W'(DEPTH));
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_cfg_reg   <= rob_pkg::DEF_CAPACITY;
            first_cfg_reg <= rob_pkg::DEF_FIRST;
            max_cfg_reg   <= rob_pkg::DEF_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                rob_pkg::REG_CAPACITY: cap_cfg_reg   <= cfg_data[rob_pkg::CAP_W-1:0];
                rob_pkg::REG_FIRST:    first_cfg_reg <= cfg_data;
                rob_pkg::REG_MAX:      max_cfg_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            idx_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            last_time_reg <= '0;
            time_seen_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= 1'b0;
            if (cmd.scan_start)
                idx_reg <= '0;
            if (cmd.scan_step)
            begin
                rd_valid_reg <= 1'b1;
                idx_reg      <= CNT_W'(idx_reg + CNT_W'(1));
            end
            if (cmd.append)
                fill_reg <= CNT_W'(fill_reg + CNT_W'(1));
            if (cmd.shift_done)
                fill_reg <= CNT_W'(fill_reg - CNT_W'(1));
            if (cmd.set_time)
            begin
                last_time_reg <= req_reg.now_ms;
                time_seen_reg <= 1'b1;
            end
        end
    end

    // payload registers and memory
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            req_reg <= req;
        if (cmd.scan_step)
        begin
            ent_rd_reg <= ent_mem[idx_lo];
            sch_rd_reg <= sch_mem[idx_lo];
            rd_idx_reg <= idx_lo;
        end
        // shift: the entry read last moves one slot down
        if (cmd.shift_step)
        begin
            ent_mem[rd_idx_dn] <= ent_rd_reg;
            sch_mem[rd_idx_dn] <= sch_rd_reg;
        end
        if (cmd.append)
        begin
            ent_mem[fill_reg[IDX_W-1:0]] <= {req_reg.action_tag, req_reg.outcome_code,
                                             req_reg.entry_payload};
            sch_mem[fill_reg[IDX_W-1:0]] <= {rob_pkg::ATT_W'(0), req_reg.now_ms};
        end
        if (cmd.bo_start)
        begin
            hit_idx_reg <= rd_idx_reg;
            att_new_reg <= (rd_att == rob_pkg::ATT_MAX) ? rd_att : rob_pkg::ATT_W'(rd_att + 1'b1);
            bo_cnt_reg  <= (rd_att == rob_pkg::ATT_MAX) ? rd_att : rob_pkg::ATT_W'(rd_att + 1'b1);
            delay_reg   <= first_eff;
        end
        if (cmd.bo_step)
        begin
            delay_reg  <= (delay_reg > (max_eff >> 1))
                          ? max_eff : {delay_reg[rob_pkg::TIME_W-2:0], 1'b0};
            bo_cnt_reg <= rob_pkg::ATT_W'(bo_cnt_reg - 1'b1);
        end
        if (cmd.update)
            sch_mem[hit_idx_reg] <= {att_new_reg, due_new};
    end

    // result register: entry taken from last read when hit
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rsp_reg.status       <= res_status;
            rsp_reg.hit          <= res_hit;
            rsp_reg.hit_tag      <= res_hit ? rd_tag : '0;
            rsp_reg.hit_outcome  <= res_hit ? ent_rd_reg[rob_pkg::PAY_W +: rob_pkg::OUTC_W] : '0;
            rsp_reg.hit_payload  <= res_hit ? ent_rd_reg[rob_pkg::PAY_W-1:0] : '0;
            rsp_reg.hit_attempts <= res_hit ? rd_att : '0;
            rsp_reg.occupancy    <= rob_pkg::CAP_W'(fill_reg);
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/rob_ctrl.sv
// retry outbox controller state machine
module rob_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  logic                         out_ready,
    input  logic [rob_pkg::FUNC_W-1:0]   func,
    input  rob_pkg::sts_t                sts,
    output rob_pkg::cmd_t                cmd,
    output logic [rob_pkg::STATUS_W-1:0] res_status,
    output logic                         res_hit
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_WAIT  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_BO    = 4'd5;
    localparam logic [3:0] S_UPD   = 4'd6;
    localparam logic [3:0] S_SHIFT = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;
    localparam logic [3:0] S_SHWR  = 4'd10;

    logic [3:0] state_reg, state_next;
    logic [rob_pkg::FUNC_W-1:0] func_reg, func_next;
    logic [rob_pkg::STATUS_W-1:0] status_reg, status_next;
    logic hit_reg, hit_next;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = (state_reg == S_OUT);
    assign res_status = status_reg;
    assign res_hit    = hit_reg;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        cmd         = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    func_next  = func;
                    hit_next   = 1'b0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN;
                case (func_reg) inside
                    rob_pkg::FN_ENQ, rob_pkg::FN_MARK:
                    begin
                        if (sts.req_bad)
                        begin
                            status_next = rob_pkg::ST_INVALID;
                            state_next  = S_FIN;
                        end
                        else if (sts.time_bad)
                        begin
                            status_next = rob_pkg::ST_NONMONO;
                            state_next  = S_FIN;
                        end
                        else
                            cmd.set_time = 1'b1;
                    end
                    rob_pkg::FN_DUE, rob_pkg::FN_ACK, rob_pkg::FN_FIND: ;
                    default:
                    begin
                        status_next = rob_pkg::ST_INVALID;
                        state_next  = S_FIN;
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    state_next = S_FIN;
                    case (func_reg)
                        rob_pkg::FN_ENQ:
                        begin
                            if (sts.full)
                                status_next = rob_pkg::ST_FULL;
                            else
                            begin
                                status_next = rob_pkg::ST_OK;
                                cmd.append  = 1'b1;
                            end
                        end
                        rob_pkg::FN_MARK: status_next = rob_pkg::ST_INVALID;
                        default:          status_next = rob_pkg::ST_NOTFOUND;
                    endcase
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (sts.scan_rd)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_SCAN;
                if (func_reg == rob_pkg::FN_DUE)
                begin
                    if (sts.due_match)
                    begin
                        status_next = rob_pkg::ST_OK;
                        hit_next    = 1'b1;
                        state_next  = S_FIN;
                    end
                end
                else if (sts.tag_match)
                begin
                    state_next = S_FIN;
                    case (func_reg)
                        rob_pkg::FN_ENQ:  status_next = rob_pkg::ST_DUP;
                        rob_pkg::FN_FIND:
                        begin
                            status_next = rob_pkg::ST_OK;
                            hit_next    = 1'b1;
                        end
                        rob_pkg::FN_MARK:
                        begin
                            if (sts.hit_late)
                                status_next = rob_pkg::ST_INVALID;
                            else
                            begin
                                status_next  = rob_pkg::ST_OK;
                                cmd.bo_start = 1'b1;
                                state_next   = S_BO;
                            end
                        end
                        default:
                        begin
                            status_next = rob_pkg::ST_OK;
                            state_next  = S_SHIFT;
                        end
                    endcase
                end
            end
            S_BO:
            begin
                if (sts.bo_done)
                    state_next = S_UPD;
                else
                    cmd.bo_step = 1'b1;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_FIN;
            end
            S_SHIFT:
            begin
                // index is one past the match: read each later entry, then write it down
                if (sts.scan_end)
                begin
                    cmd.shift_done = 1'b1;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    state_next    = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.shift_step = 1'b1;
                state_next     = S_SHIFT;
            end
            S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            func_reg   <= '0;
            status_reg <= '0;
            hit_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
        end
    end

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !out_ready) |=> (state_reg == S_OUT))
        else $error("result dropped while stalled");
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ready)
        else $error("request taken while busy");
    a_fin_then_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) |=> (state_reg == S_OUT))
        else $error("result not presented after finish");
    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && hit_reg) |-> (status_reg == rob_pkg::ST_OK))
        else $error("hit without ok status");

endmodule

### tb/tb_retry_outbox_with_backoff_unit.sv
// testbench of the retry outbox with backoff: self-predicting driver and monitor
`timescale 1ns / 100ps

module tb_retry_outbox_with_backoff_unit;

    localparam int unsigned TBL_DEPTH = 64;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [rob_pkg::CFG_IDX_W-1:0] cfg_idx;
    logic [rob_pkg::CFG_DAT_W-1:0] cfg_data;

    rob_if #(.T(rob_pkg::req_t)) req_ch ();
    rob_if #(.T(rob_pkg::rsp_t)) rsp_ch ();

    retry_outbox_with_backoff_unit #(.DEPTH(TBL_DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_ch   (req_ch.sink),
        .rsp_ch   (rsp_ch.source),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    // requests still to be offered and results still awaited
    rob_pkg::req_t pending_reqs[$];
    rob_pkg::rsp_t expected_rsps[$];

    int unsigned n_accepted;
    int unsigned n_checked;
    int unsigned n_errors;
    logic [rob_pkg::TIME_W-1:0] cur_time;

    // mirror of the outbox: register copy and table contents
    logic [rob_pkg::CAP_W-1:0]  cap_reg;
    logic [rob_pkg::TIME_W-1:0] first_reg;
    logic [rob_pkg::TIME_W-1:0] max_reg;
    logic [rob_pkg::TAG_W-1:0]  tbl_tag     [TBL_DEPTH];
    logic [rob_pkg::OUTC_W-1:0] tbl_outcome [TBL_DEPTH];
    logic [rob_pkg::PAY_W-1:0]  tbl_payload [TBL_DEPTH];
    logic [rob_pkg::ATT_W-1:0]  tbl_attempts[TBL_DEPTH];
    logic [rob_pkg::TIME_W-1:0] tbl_due     [TBL_DEPTH];
    int unsigned                tbl_fill;
    logic [rob_pkg::TIME_W-1:0] last_time;
    logic                       time_seen;

    // clock, 8 ns period
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // index of the entry holding a tag, or -1
    function automatic int tbl_locate(logic [rob_pkg::TAG_W-1:0] tag);
        for (int i = 0; i < tbl_fill; i++)
            if (tbl_tag[i] == tag)
                return i;
        return -1;
    endfunction

    // monotonic time check, records the time when it passes
    function automatic bit time_accept(logic [rob_pkg::TIME_W-1:0] now);
        if (time_seen && now < last_time)
            return 1'b0;
        last_time = now;
        time_seen = 1'b1;
        return 1'b1;
    endfunction

    // apply one request to the mirror and work out its result
    function automatic rob_pkg::rsp_t outbox_predict(rob_pkg::req_t r);
        rob_pkg::rsp_t              res;
        int unsigned                cap;
        logic [rob_pkg::TIME_W-1:0] first_d;
        logic [rob_pkg::TIME_W-1:0] max_d;
        logic [rob_pkg::TIME_W-1:0] dly;
        int                         k;
        int                         hit_idx;
        res = '0;
        hit_idx = -1;
        // invalid settings fall back to the defaults as a set
        if (cap_reg == 0 || first_reg == 0 || max_reg < first_reg)
        begin
            cap = 32'(rob_pkg::DEF_CAPACITY);
            first_d = rob_pkg::DEF_FIRST;
            max_d = rob_pkg::DEF_MAX;
        end
        else
        begin
            cap = 32'(cap_reg);
            first_d = first_reg;
            max_d = max_reg;
        end
        if (cap > TBL_DEPTH)
            cap = TBL_DEPTH;
        res.status = rob_pkg::ST_INVALID;
        case (r.func)
            rob_pkg::FN_ENQ:
            begin
                if (r.action_tag == 0 || r.outcome_code == rob_pkg::OUTC_BAD
                    || !r.position_finite)
                    res.status = rob_pkg::ST_INVALID;
                else if (!time_accept(r.now_ms))
                    res.status = rob_pkg::ST_NONMONO;
                else if (tbl_locate(r.action_tag) >= 0)
                    res.status = rob_pkg::ST_DUP;
                else if (tbl_fill >= cap)
                    res.status = rob_pkg::ST_FULL;
                else
                begin
                    tbl_tag[tbl_fill] = r.action_tag;
                    tbl_outcome[tbl_fill] = r.outcome_code;
                    tbl_payload[tbl_fill] = r.entry_payload;
                    tbl_attempts[tbl_fill] = '0;
                    tbl_due[tbl_fill] = r.now_ms;
                    tbl_fill++;
                    res.status = rob_pkg::ST_OK;
                end
            end
            rob_pkg::FN_DUE:
            begin
                res.status = rob_pkg::ST_NOTFOUND;
                for (int i = 0; i < tbl_fill; i++)
                    if (tbl_due[i] <= r.now_ms)
                    begin
                        hit_idx = i;
                        res.status = rob_pkg::ST_OK;
                        break;
                    end
            end
            rob_pkg::FN_MARK:
            begin
                if (r.action_tag == 0)
                    res.status = rob_pkg::ST_INVALID;
                else if (!time_accept(r.now_ms))
                    res.status = rob_pkg::ST_NONMONO;
                else
                begin
                    k = tbl_locate(r.action_tag);
                    if (k < 0 || tbl_due[k] > r.now_ms)
                        res.status = rob_pkg::ST_INVALID;
                    else
                    begin
                        if (tbl_attempts[k] != rob_pkg::ATT_MAX)
                            tbl_attempts[k]++;
                        // doubling delay, stops at the cap
                        dly = first_d;
                        for (int i = 1; i < tbl_attempts[k] && dly < max_d; i++)
                            dly = (dly > max_d / 2) ? max_d : dly * 2;
                        tbl_due[k] = (r.now_ms > rob_pkg::TIME_MAX - dly)
                                     ? rob_pkg::TIME_MAX : r.now_ms + dly;
                        res.status = rob_pkg::ST_OK;
                    end
                end
            end
            rob_pkg::FN_ACK:
            begin
                k = tbl_locate(r.action_tag);
                if (k < 0)
                    res.status = rob_pkg::ST_NOTFOUND;
                else
                begin
                    // close the gap, order kept
                    for (int i = k; i + 1 < tbl_fill; i++)
                    begin
                        tbl_tag[i] = tbl_tag[i+1];
                        tbl_outcome[i] = tbl_outcome[i+1];
                        tbl_payload[i] = tbl_payload[i+1];
                        tbl_attempts[i] = tbl_attempts[i+1];
                        tbl_due[i] = tbl_due[i+1];
                    end
                    tbl_fill--;
                    res.status = rob_pkg::ST_OK;
                end
            end
            rob_pkg::FN_FIND:
            begin
                k = tbl_locate(r.action_tag);
                if (k < 0)
                    res.status = rob_pkg::ST_NOTFOUND;
                else
                begin
                    hit_idx = k;
                    res.status = rob_pkg::ST_OK;
                end
            end
            default: res.status = rob_pkg::ST_INVALID;
        endcase
        if (hit_idx >= 0)
        begin
            res.hit = 1'b1;
            res.hit_tag = tbl_tag[hit_idx];
            res.hit_outcome = tbl_outcome[hit_idx];
            res.hit_payload = tbl_payload[hit_idx];
            res.hit_attempts = tbl_attempts[hit_idx];
        end
        res.occupancy = tbl_fill[rob_pkg::CAP_W-1:0];
        return res;
    endfunction

    // one line per mismatching field
    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR result %0d field %s: got 0x%0h expected 0x%0h",
                 n_checked, what, got, want);
        n_errors++;
    endtask

    // idling pattern follows progress: sender light / receiver heavy,
    // then the reverse, then no idling at all
    function automatic bit sender_idles();
        if (n_accepted < 160)
            return $urandom_range(0, 99) < 7;
        if (n_accepted < 320)
            return $urandom_range(0, 99) < 71;
        return 1'b0;
    endfunction

    function automatic bit receiver_idles();
        if (n_accepted < 160)
            return $urandom_range(0, 99) < 71;
        if (n_accepted < 320)
            return $urandom_range(0, 99) < 7;
        return 1'b0;
    endfunction

    // driver: offers the oldest pending request, predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                expected_rsps.insert(expected_rsps.size(), outbox_predict(req_ch.data));
                void'(pending_reqs.pop_front());
                n_accepted++;
            end
            // a request on offer and not yet taken must stay put
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (pending_reqs.size() > 0 && !sender_idles())
                begin
                    req_ch.valid <= 1'b1;
                    req_ch.data  <= pending_reqs[0];
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure, field-by-field check
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $display("ERROR result with no request outstanding");
                    n_errors++;
                end
                else
                begin
                    rob_pkg::rsp_t want;
                    rob_pkg::rsp_t got;
                    want = expected_rsps.pop_front();
                    got = rsp_ch.data;
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.hit !== want.hit)
                        report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                    if (got.hit_tag !== want.hit_tag)
                        report_mismatch("hit_tag", 64'(got.hit_tag), 64'(want.hit_tag));
                    if (got.hit_outcome !== want.hit_outcome)
                        report_mismatch("hit_outcome", 64'(got.hit_outcome),
                                        64'(want.hit_outcome));
                    if (got.hit_payload !== want.hit_payload)
                        report_mismatch("hit_payload", got.hit_payload, want.hit_payload);
                    if (got.hit_attempts !== want.hit_attempts)
                        report_mismatch("hit_attempts", 64'(got.hit_attempts),
                                        64'(want.hit_attempts));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch("occupancy", 64'(got.occupancy), 64'(want.occupancy));
                end
                n_checked++;
            end
            rsp_ch.ready <= !receiver_idles();
        end
    end

    task automatic queue_request(logic [rob_pkg::FUNC_W-1:0] f,
                                 logic [rob_pkg::TAG_W-1:0] tag,
                                 logic [rob_pkg::OUTC_W-1:0] oc, logic fin,
                                 logic [rob_pkg::PAY_W-1:0] pay,
                                 logic [rob_pkg::TIME_W-1:0] now);
        rob_pkg::req_t r;
        r.func = f;
        r.action_tag = tag;
        r.outcome_code = oc;
        r.position_finite = fin;
        r.entry_payload = pay;
        r.now_ms = now;
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // register write, mirrored at the same moment
    task automatic write_reg(logic [rob_pkg::CFG_IDX_W-1:0] idx,
                             logic [rob_pkg::CFG_DAT_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            rob_pkg::REG_CAPACITY: cap_reg = val[rob_pkg::CAP_W-1:0];
            rob_pkg::REG_FIRST:    first_reg = val;
            rob_pkg::REG_MAX:      max_reg = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(logic [rob_pkg::CFG_DAT_W-1:0] cap,
                            logic [rob_pkg::CFG_DAT_W-1:0] fd,
                            logic [rob_pkg::CFG_DAT_W-1:0] md);
        write_reg(rob_pkg::REG_CAPACITY, cap);
        write_reg(rob_pkg::REG_FIRST, fd);
        write_reg(rob_pkg::REG_MAX, md);
    endtask

    // let every request finish before touching the registers
    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (250) @(posedge clk);
    endtask

    // time moves forward, saturating at the top
    function automatic logic [rob_pkg::TIME_W-1:0] advance_time(int unsigned step);
        logic [rob_pkg::TIME_W:0] sum;
        sum = {1'b0, cur_time} + step;
        cur_time = sum[rob_pkg::TIME_W] ? rob_pkg::TIME_MAX : sum[rob_pkg::TIME_W-1:0];
        return cur_time;
    endfunction

    function automatic logic [rob_pkg::TAG_W-1:0] pick_tag();
        if ($urandom_range(0, 9) == 0)
            return rob_pkg::TAG_W'($urandom);
        return rob_pkg::TAG_W'($urandom_range(1, 10));
    endfunction

    // mostly well-formed traffic on a small tag pool, with some noise
    task automatic queue_random(int unsigned count);
        int unsigned                kind;
        logic [rob_pkg::TIME_W-1:0] now;
        logic [rob_pkg::PAY_W-1:0]  pay;
        logic [rob_pkg::OUTC_W-1:0] oc;
        logic                       fin;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            pay = {$urandom, $urandom};
            // a step back in time now and then
            if ($urandom_range(0, 99) < 8)
                now = cur_time - $urandom_range(0, 50);
            else
                now = advance_time($urandom_range(0, 400));
            if (kind < 35)
            begin
                oc = ($urandom_range(0, 9) == 0) ? rob_pkg::OUTC_BAD
                                                 : rob_pkg::OUTC_W'($urandom_range(0, 2));
                fin = ($urandom_range(0, 9) != 0);
                queue_request(rob_pkg::FN_ENQ, pick_tag(), oc, fin, pay, now);
            end
            else if (kind < 50)
            begin
                if ($urandom_range(0, 9) == 0)
                    now = $urandom;
                else
                    now = cur_time + $urandom_range(0, 6000);
                queue_request(rob_pkg::FN_DUE, pick_tag(), rob_pkg::OUTC_W'($urandom),
                              1'($urandom), pay, now);
            end
            else if (kind < 70)
                queue_request(rob_pkg::FN_MARK, pick_tag(), rob_pkg::OUTC_W'($urandom),
                              1'($urandom), pay, now);
            else if (kind < 85)
                queue_request(rob_pkg::FN_ACK, pick_tag(), rob_pkg::OUTC_W'($urandom),
                              1'($urandom), pay, now);
            else if (kind < 95)
                queue_request(rob_pkg::FN_FIND, pick_tag(), rob_pkg::OUTC_W'($urandom),
                              1'($urandom), pay, now);
            else
                queue_request(rob_pkg::FUNC_W'($urandom_range(5, 7)),
                              rob_pkg::TAG_W'($urandom), rob_pkg::OUTC_W'($urandom),
                              1'($urandom), pay, now);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        n_accepted = 0;
        n_checked = 0;
        n_errors = 0;
        cur_time = 32'd1000;
        cap_reg = rob_pkg::DEF_CAPACITY;
        first_reg = rob_pkg::DEF_FIRST;
        max_reg = rob_pkg::DEF_MAX;
        tbl_fill = 0;
        last_time = '0;
        time_seen = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, rejects, every operation, default settings
        queue_request(rob_pkg::FN_ENQ, 16'd0, 2'd0, 1'b1, '0, 32'd1000);
        queue_request(rob_pkg::FN_ENQ, 16'd5, rob_pkg::OUTC_BAD, 1'b1, '0, 32'd1000);
        queue_request(rob_pkg::FN_ENQ, 16'd5, 2'd1, 1'b0, '0, 32'd1000);
        queue_request(rob_pkg::FN_ENQ, 16'hFFFF, 2'd2, 1'b1, {64{1'b1}}, 32'd1000);
        queue_request(rob_pkg::FN_ENQ, 16'd1, 2'd0, 1'b1, '0, 32'd1000);
        queue_request(rob_pkg::FN_ENQ, 16'd1, 2'd1, 1'b1, 64'h1234, 32'd1001);
        queue_request(rob_pkg::FN_DUE, 16'd0, 2'd0, 1'b0, '0, 32'd999);
        queue_request(rob_pkg::FN_DUE, 16'd0, 2'd0, 1'b0, '0, 32'd1001);
        queue_request(rob_pkg::FN_FIND, 16'd1, 2'd0, 1'b0, '0, 32'd0);
        queue_request(rob_pkg::FN_FIND, 16'd77, 2'd0, 1'b0, '0, 32'd0);
        queue_request(rob_pkg::FN_MARK, 16'd0, 2'd0, 1'b0, '0, 32'd1002);
        queue_request(rob_pkg::FN_MARK, 16'd77, 2'd0, 1'b0, '0, 32'd1002);
        queue_request(rob_pkg::FN_MARK, 16'hFFFF, 2'd0, 1'b0, '0, 32'd1003);
        // second try before the entry is due again
        queue_request(rob_pkg::FN_MARK, 16'hFFFF, 2'd0, 1'b0, '0, 32'd1010);
        queue_request(rob_pkg::FN_MARK, 16'd1, 2'd0, 1'b0, '0, 32'd900);
        queue_request(rob_pkg::FN_ENQ, 16'd9, 2'd0, 1'b1, '0, 32'd900);
        queue_request(rob_pkg::FN_MARK, 16'hFFFF, 2'd0, 1'b0, '0, 32'd1253);
        queue_request(rob_pkg::FN_FIND, 16'hFFFF, 2'd0, 1'b0, '0, 32'd0);
        queue_request(rob_pkg::FN_ACK, 16'd77, 2'd0, 1'b0, '0, 32'd0);
        queue_request(rob_pkg::FN_ACK, 16'hFFFF, 2'd0, 1'b0, '0, 32'd0);
        queue_request(rob_pkg::FN_FIND, 16'd1, 2'd0, 1'b0, '0, 32'd0);
        queue_request(3'd5, 16'd1, 2'd0, 1'b1, '0, 32'd2000);
        queue_request(3'd7, 16'hFFFF, 2'd3, 1'b1, {64{1'b1}}, rob_pkg::TIME_MAX);
        drain();

        // tiny table: enqueues stamped before the last recorded time, then capacity set equal to the fill count
        set_regs(32'd3, 32'd1, 32'd8);
        for (int i = 0; i < 4; i++)
            queue_request(rob_pkg::FN_ENQ, rob_pkg::TAG_W'(20 + i), 2'd1, 1'b1,
                          {$urandom, $urandom}, advance_time(5));
        drain();
        write_reg(rob_pkg::REG_CAPACITY, 32'd1);
        queue_request(rob_pkg::FN_ENQ, 16'd30, 2'd0, 1'b1, '0, advance_time(5));
        queue_request(rob_pkg::FN_ACK, 16'd1, 2'd0, 1'b0, '0, 32'd0);
        queue_random(60);
        drain();

        // random phases over several settings, extremes included
        set_regs(32'd3, 32'd1, 32'd8);
        queue_random(70);
        drain();
        set_regs(32'd64, 32'd250, 32'd5000);
        queue_random(70);
        drain();
        // zero capacity: whole set falls back to defaults
        set_regs(32'd0, 32'd7, 32'd9);
        queue_random(50);
        drain();
        // capacity above the table, largest delays: due times saturate
        set_regs(32'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_random(60);
        drain();
        // cap below first delay: defaults again
        set_regs(32'd20, 32'd100, 32'd50);
        queue_random(50);
        drain();
        // fast backoff near the top of the time range
        set_regs(32'd64, 32'd1, 32'hFFFF_FFFF);
        cur_time = 32'hFFFF_F000;
        queue_random(90);
        drain();

        $display("run covered %0d requests and %0d results over a range of register settings",
                 n_accepted, n_checked);
        if (n_errors == 0)
            $display("retry_outbox_with_backoff_unit: match");
        else
            $display("retry_outbox_with_backoff_unit: mismatch");
        $finish;
    end

    // hard limit on run length
    initial
    begin
        #40ms;
        $display("timeout with %0d results outstanding", expected_rsps.size());
        $display("retry_outbox_with_backoff_unit: mismatch");
        $finish;
    end

endmodule

### filelist.f
rtl/rob_pkg.sv
rtl/rob_if.sv
rtl/rob_datapath.sv
rtl/rob_ctrl.sv
rtl/retry_outbox_with_backoff_unit.sv
tb/tb_retry_outbox_with_backoff_unit.sv
